[hdl/rms_pkg.sv]
// Shared constants, widths and types of the regret matching strategy block.
package rms_pkg;

    localparam int MAX_ACTIONS = 8;

    localparam int ACT_W    = 3;
    localparam int REGRET_W = 32;
    localparam int POS_W    = 31;
    localparam int PROB_W   = 17;

    localparam int IDX_W   = $clog2(MAX_ACTIONS);
    localparam int CNT_W   = $clog2(MAX_ACTIONS + 1);
    localparam int SUM_W   = POS_W + $clog2(MAX_ACTIONS);
    localparam int ENTRY_W = ACT_W + POS_W;
    localparam int STEP_W  = $clog2(PROB_W + 1);

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

    typedef struct packed {
        logic             start;
        logic [SUM_W:0]   rem;
        logic [SUM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [PROB_W-1:0] quot;
    } t_div_rsp;

endpackage

[hdl/rms_in_if.sv]
// Load channel: one legal action per beat.
interface rms_in_if;
    import rms_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action_index;
    logic [REGRET_W-1:0] regret;
    logic                last;

    modport source (output valid, output action_index, output regret, output last,
                    input ready);
    modport sink   (input valid, input action_index, input regret, input last,
                    output ready);
endinterface

[hdl/rms_out_if.sv]
// Result channel: one strategy probability per beat.
interface rms_out_if;
    import rms_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  out_action;
    logic [PROB_W-1:0] probability;
    logic              final_entry;
    logic              dropped;

    modport source (output valid, output out_action, output probability,
                    output final_entry, output dropped, input ready);
    modport sink   (input valid, input out_action, input probability,
                    input final_entry, input dropped, output ready);
endinterface

[hdl/rms_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module rms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/rms_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle into a shift register.
module rms_divider
    import rms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W:0]    r_rem;
    logic [SUM_W-1:0]  r_div;
    logic [PROB_W-1:0] r_quot;

    logic [SUM_W+1:0]  diff;
    logic              ge;
    logic [SUM_W:0]    rem_sub;
    logic [SUM_W:0]    n_rem;

    // The partial remainder always stays below twice the divisor.
    always_comb begin
        diff    = {1'b0, r_rem} - {2'b00, r_div};
        ge      = ~diff[SUM_W+1];
        rem_sub = ge ? diff[SUM_W:0] : r_rem;
        n_rem   = {rem_sub[SUM_W-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(PROB_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_div  <= i_req.divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[PROB_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;

endmodule

[hdl/regret_matching_strategy.sv]
// Top level of the regret matching strategy block: load, store and emit.
//
//  Channel  | Dir | Modport | Beat contents
//  ---------+-----+---------+-------------------------------------------------
//  i_in     | in  | sink    | action_index, regret (signed Q16.16), last
//  o_out    | out | source  | out_action, probability (Q1.16), final_entry,
//           |     |         | dropped
//
// Ready is high whenever the block is loading. After the beat marked last,
// each stored action passes in turn through a RAM read, a divider start, the
// bit-serial divider and a push into the output register.
// Reset (synchronous, active low) clears the run counters, the state and the
// output valid; the action RAM is not cleared, since only entries written in
// the current run are read.
// A stalled output beat holds in its register; the divider result then waits,
// and after the final beat is pushed loading of the next run may begin.
module regret_matching_strategy
    import rms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rms_in_if.sink    i_in,
    rms_out_if.source o_out
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_START,
        S_DIV
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_rd_ptr;
    logic [ACT_W-1:0]  r_cur_action;

    logic              r_out_valid;
    logic [ACT_W-1:0]  r_out_action;
    logic [PROB_W-1:0] r_out_prob;
    logic              r_out_final;
    logic              r_out_drop;

    logic              in_acc;
    logic              has_room;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  n_count;
    logic              out_free;
    logic              push;
    logic              is_final;

    logic [ENTRY_W-1:0] rd_data;
    logic [POS_W-1:0]   rd_pos;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // Loading: a beat is taken only while no run is being emitted.
    assign i_in.ready = (r_state == S_LOAD);
    assign in_acc     = i_in.valid && i_in.ready;
    assign has_room   = (r_count < CNT_W'(MAX_ACTIONS));

    // Negative regrets count as zero; the positive part fits in 31 bits.
    assign pos = i_in.regret[REGRET_W-1] ? '0 : i_in.regret[POS_W-1:0];

    assign n_count = has_room ? (r_count + CNT_W'(1)) : r_count;

    rms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ACTIONS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && has_room),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({i_in.action_index, pos}),
        .i_rd_addr (r_rd_ptr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_pos = rd_data[POS_W-1:0];

    // A zero sum turns the division into 65536 / count, which the same unit
    // handles with a remainder seed of one (one shifted up sixteen places).
    always_comb begin
        div_req.start = (r_state == S_START);
        if (r_sum != '0) begin
            div_req.rem     = (SUM_W + 1)'(rd_pos);
            div_req.divisor = r_sum;
        end else begin
            div_req.rem     = (SUM_W + 1)'(1);
            div_req.divisor = SUM_W'(r_count);
        end
    end

    rms_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign push     = (r_state == S_DIV) && !div_rsp.busy && out_free;
    assign is_final = ((r_rd_ptr + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if (has_room) begin
                            r_sum <= r_sum + SUM_W'(pos);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.last && (n_count != '0)) begin
                            r_rd_ptr <= '0;
                            r_state  <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_cur_action <= rd_data[ENTRY_W-1 -: ACT_W];
                    r_state      <= S_DIV;
                end
                S_DIV: begin
                    if (push) begin
                        r_out_action <= r_cur_action;
                        r_out_prob   <= div_rsp.quot;
                        r_out_final  <= is_final;
                        r_out_drop   <= r_ovf;
                        if (is_final) begin
                            r_count <= '0;
                            r_sum   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_rd_ptr <= r_rd_ptr + CNT_W'(1);
                            r_state  <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_action  = r_out_action;
    assign o_out.probability = r_out_prob;
    assign o_out.final_entry = r_out_final;
    assign o_out.dropped     = r_out_drop;

    // The entry count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ACTIONS))
        else $error("entry count exceeds capacity");

    // While emitting, the read pointer stays inside the stored entries.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_rd_ptr < r_count))
        else $error("read pointer beyond stored entries");

    // A finished quotient never exceeds one in Q1.16.
    a_quot_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (div_rsp.quot <= ONE_Q16))
        else $error("probability above one");

    // Pushing the final beat of a run returns the block to loading.
    a_final_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && is_final) |=> (r_state == S_LOAD))
        else $error("run still emitting after its final beat");

    // A stalled output register is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out_prob))
        else $error("stalled result overwritten");

endmodule

[dv/testbench.sv]
// Self-checking testbench of the regret matching strategy block.
`timescale 1ns / 100ps

module testbench;
    import rms_pkg::*;

    // One expected probability beat on the result channel.
    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [PROB_W-1:0] prob;
        logic              fin;
        logic              drop;
    } t_prob_beat;

    // Mirror of the action store.
    // note_load() follows every accepted load beat. On the beat marked last, it
    // turns the stored actions into the probabilities that the block must emit.
    // check_prob() compares each emitted beat against the oldest of those.
    class prob_scoreboard;
        logic [ACT_W-1:0] slot_act[MAX_ACTIONS];
        logic [POS_W-1:0] slot_pos[MAX_ACTIONS];
        int unsigned      fill;
        logic [SUM_W-1:0] pos_sum = '0;
        bit               spilled;
        t_prob_beat       expected_probs[$];
        int unsigned      mismatches;
        int unsigned      loads;
        int unsigned      sets;
        int unsigned      spilled_sets;
        int unsigned      probs_checked;

        function void note_load(logic [ACT_W-1:0] act, logic [REGRET_W-1:0] regret,
                                logic last);
            logic [POS_W-1:0]   pos;
            longint unsigned    quot;
            t_prob_beat         beat;
            // A negative regret contributes nothing; the sign bit clears it.
            pos = regret[REGRET_W-1] ? '0 : regret[POS_W-1:0];
            loads++;
            if (fill < MAX_ACTIONS) begin
                slot_act[fill] = act;
                slot_pos[fill] = pos;
                pos_sum += pos;
                fill++;
            end else begin
                // The store is full: the action is discarded and the run is flagged.
                spilled = 1'b1;
            end
            if (!last) return;
            sets++;
            if (spilled) spilled_sets++;
            for (int k = 0; k < fill; k++) begin
                if (pos_sum != 0)
                    quot = (longint'(slot_pos[k]) << 16) / longint'(pos_sum);
                else
                    quot = 65536 / fill;   // no positive regret: uniform strategy
                beat.act  = slot_act[k];
                beat.prob = quot[PROB_W-1:0];
                beat.fin  = (k + 1 == fill);
                beat.drop = spilled;
                expected_probs = {expected_probs, beat};
            end
            fill    = 0;
            pos_sum = '0;
            spilled = 1'b0;
        endfunction

        function void check_prob(logic [ACT_W-1:0] act, logic [PROB_W-1:0] prob,
                                 logic fin, logic drop);
            t_prob_beat want;
            if (expected_probs.size() == 0) begin
                $error("unexpected beat: out_action %0d, probability %0d",
                       act, prob);
                mismatches++;
                return;
            end
            want = expected_probs.pop_front();
            probs_checked++;
            if (act !== want.act) begin
                $error("out_action: expected %0d, got %0d", want.act, act);
                mismatches++;
            end
            if (prob !== want.prob) begin
                $error("probability: expected %0d, got %0d", want.prob, prob);
                mismatches++;
            end
            if (fin !== want.fin) begin
                $error("final_entry: expected %0d, got %0d", want.fin, fin);
                mismatches++;
            end
            if (drop !== want.drop) begin
                $error("dropped: expected %0d, got %0d", want.drop, drop);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_probs.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rms_in_if  load_ch ();
    rms_out_if prob_ch ();

    regret_matching_strategy uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (load_ch),
        .o_out   (prob_ch)
    );

    prob_scoreboard board = new();

    // When set, the corresponding side runs without any idle cycles, so that
    // back-to-back beats are exercised as well as scattered ones.
    bit tx_burst;
    bit rx_burst;

    always #1 i_clk = ~i_clk;

    // Present one action on the load channel and wait until the block takes it.
    // The task returns in the time step of the accepting edge, and valid is left
    // high so that the next call can either keep it up or drop it for a gap.
    task automatic load_beat(logic [ACT_W-1:0] act, logic [REGRET_W-1:0] regret,
                             logic last);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            load_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        load_ch.valid        <= 1'b1;
        load_ch.action_index <= act;
        load_ch.regret       <= regret;
        load_ch.last         <= last;
        // While the block emits a previous set, ready stays low and the beat waits.
        do @(posedge i_clk); while (load_ch.ready !== 1'b1);
        board.note_load(act, regret, last);
    endtask

    // Regret values are weighted toward the interesting corners: zero, the
    // largest positive value, the most negative one, and small magnitudes so
    // that probabilities other than 0 and 65536 come out often.
    function automatic logic [REGRET_W-1:0] draw_regret(bit non_positive);
        logic [REGRET_W-1:0] r;
        case ($urandom_range(0, 7))
            0:       r = '0;
            1:       r = 32'h7FFF_FFFF;
            2:       r = 32'h8000_0000;
            3:       r = $urandom_range(1, 32'h0004_0000);
            4:       r = -$urandom_range(1, 32'h0004_0000);
            default: r = $urandom;
        endcase
        // A set with no positive regret at all takes the uniform path.
        if (non_positive && !r[REGRET_W-1]) r = '0;
        return r;
    endfunction

    // One complete set: a few well-formed actions, sometimes more than the
    // store holds, with the last flag on the final beat.
    task automatic random_set();
        int unsigned n;
        bit          non_positive;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_ACTIONS + 1, MAX_ACTIONS + 4)
                                        : $urandom_range(1, MAX_ACTIONS);
        non_positive = ($urandom_range(0, 7) == 0);
        tx_burst     = ($urandom_range(0, 3) == 0);
        rx_burst     = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < n; k++)
            load_beat(ACT_W'($urandom_range(0, 7)), draw_regret(non_positive),
                      k == n - 1);
    endtask

    // Result side: a random stall before each beat, then ready until one is taken.
    initial begin
        int unsigned stall;
        prob_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                prob_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            prob_ch.ready <= 1'b1;
            do @(posedge i_clk); while (prob_ch.valid !== 1'b1);
            board.check_prob(prob_ch.out_action, prob_ch.probability,
                             prob_ch.final_entry, prob_ch.dropped);
        end
    end

    // Main sequence: reset, directed sets, random sets, drain and verdict.
    initial begin
        load_ch.valid        <= 1'b0;
        load_ch.action_index <= '0;
        load_ch.regret       <= '0;
        load_ch.last         <= 1'b0;
        i_rst_n              <= 1'b0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single action sets: the largest regret takes the whole probability,
        // and a lone action without positive regret gets it from the uniform rule.
        load_beat(3'd7, 32'h7FFF_FFFF, 1'b1);
        load_beat(3'd0, 32'h8000_0000, 1'b1);
        // Negative and zero regrets count as nothing next to a tiny positive one.
        load_beat(3'd1, 32'hFFFF_FFFF, 1'b0);
        load_beat(3'd2, 32'h0000_0000, 1'b0);
        load_beat(3'd3, 32'h0000_0001, 1'b1);
        // No positive regret in a set of three: each action gets a third.
        load_beat(3'd4, 32'h0000_0000, 1'b0);
        load_beat(3'd5, 32'hFFFF_FFFB, 1'b0);
        load_beat(3'd6, 32'h8000_0000, 1'b1);
        // The same index twice, both at the top of the range: the sum needs a carry past 31 bits.
        load_beat(3'd5, 32'h7FFF_FFFF, 1'b0);
        load_beat(3'd5, 32'h7FFF_FFFF, 1'b1);
        // A full store, then two extra actions that are discarded.
        for (int k = 0; k < MAX_ACTIONS; k++)
            load_beat(ACT_W'(k), $urandom, 1'b0);
        load_beat(3'd3, 32'h0001_0000, 1'b0);
        load_beat(3'd5, 32'h7FFF_FFFF, 1'b1);
        // A full store whose last flag arrives on the discarded action itself.
        for (int k = 0; k < MAX_ACTIONS; k++)
            load_beat(ACT_W'(7 - k), 32'h0000_8000 << (k % 4), 1'b0);
        load_beat(3'd2, 32'h8000_0000, 1'b1);

        while (board.loads < 310)
            random_set();
        load_ch.valid <= 1'b0;

        // Let the last divisions finish, then allow for any stray beat.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Loaded %0d actions in %0d sets, %0d of them over capacity.",
                 board.loads, board.sets, board.spilled_sets);
        $display("Checked %0d probability beats, %0d field mismatches.",
                 board.probs_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
